// File: rtl/tav_pkg.sv
`default_nettype none

package tav_pkg;

   localparam int RING_DEPTH = 8;
   localparam int SAMPLE_BITS = 10;
   localparam int THRESHOLD_BITS = 10;
   localparam int LIMIT_BITS = 32;
   localparam int TIME_BITS = 32;
   localparam int OP_BITS = 2;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_RISE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FALL = 2'd2;
   localparam logic [OP_BITS-1:0] OP_PRIME = 2'd3;

   localparam logic CSR_DRIVE_THRESHOLD = 1'b0;
   localparam logic CSR_PRESS_TIME_LIMIT = 1'b1;

   localparam logic [THRESHOLD_BITS-1:0] RESET_THRESHOLD = 10'd300;
   localparam logic [LIMIT_BITS-1:0] RESET_PRESS_LIMIT = 32'd500000;

   typedef struct packed {
      logic power_cur;
      logic power_next;
      logic switched_off;
   } power_status_type;

endpackage

`default_nettype wire

// File: rtl/tav_cell.sv
`default_nettype none

module tav_cell #(
   parameter int WIDTH = tav_pkg::SAMPLE_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             shift_en,
   input  wire logic             load_en,
   input  wire logic [WIDTH-1:0] shift_value,
   input  wire logic [WIDTH-1:0] load_value,
   output logic      [WIDTH-1:0] value
);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = load_value;
      end else if (shift_en) begin
         value_in = shift_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: rtl/tav_ring.sv
`default_nettype none

module tav_ring #(
   parameter int RING_DEPTH = tav_pkg::RING_DEPTH,
   parameter int SAMPLE_BITS = tav_pkg::SAMPLE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                sample_en,
   input  wire logic                                prime_en,
   input  wire logic [SAMPLE_BITS-1:0]              sample,
   input  wire logic [tav_pkg::THRESHOLD_BITS-1:0]  threshold,
   output logic                                     drive_level
);

   localparam int SUM_BITS = SAMPLE_BITS + $clog2(RING_DEPTH);
   localparam int LIM_BITS = tav_pkg::THRESHOLD_BITS + 1 + $clog2(RING_DEPTH);
   localparam int CMP_BITS = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

   logic [SAMPLE_BITS-1:0] cell_value [RING_DEPTH];
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic [SUM_BITS-1:0]    shifted_sum;
   logic [LIM_BITS-1:0]    level_limit;

   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] shift_value;
      if (i == 0) begin : g_head
         assign shift_value = sample;
      end else begin : g_body
         assign shift_value = cell_value[i-1];
      end
      tav_cell #(
         .WIDTH(SAMPLE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (sample_en),
         .load_en     (prime_en),
         .shift_value (shift_value),
         .load_value  (sample),
         .value       (cell_value[i])
      );
   end

   // The mean exceeds the threshold exactly when the sum reaches
   // (threshold + 1) times the depth.
   assign shifted_sum = sum_ff - SUM_BITS'(cell_value[RING_DEPTH-1]) + SUM_BITS'(sample);
   assign level_limit = (LIM_BITS'(threshold) + LIM_BITS'(1)) * LIM_BITS'(RING_DEPTH);
   assign drive_level = CMP_BITS'(shifted_sum) >= CMP_BITS'(level_limit);

   always_comb begin
      sum_in = sum_ff;
      if (prime_en) begin
         sum_in = SUM_BITS'(sample) * SUM_BITS'(RING_DEPTH);
      end else if (sample_en) begin
         sum_in = shifted_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tav_press.sv
`default_nettype none

module tav_press (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [tav_pkg::OP_BITS-1:0]        operation,
   input  wire logic [tav_pkg::TIME_BITS-1:0]      time_us,
   input  wire logic [tav_pkg::LIMIT_BITS-1:0]     press_limit,
   output tav_pkg::power_status_type               status
);

   logic [tav_pkg::TIME_BITS-1:0] rise_ff;
   logic [tav_pkg::TIME_BITS-1:0] rise_in;
   logic                          power_ff;
   logic                          power_in;
   logic [tav_pkg::TIME_BITS-1:0] press_length;
   logic                          toggle;

   assign press_length = time_us - rise_ff;
   assign toggle = (operation == tav_pkg::OP_FALL) &&
                   (tav_pkg::LIMIT_BITS'(press_length) > press_limit);

   assign status.power_cur = power_ff;
   assign status.power_next = toggle ? !power_ff : power_ff;
   assign status.switched_off = toggle && power_ff;

   always_comb begin
      rise_in = rise_ff;
      power_in = power_ff;
      if (accept) begin
         power_in = status.power_next;
         if (operation == tav_pkg::OP_RISE) begin
            rise_in = time_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= '0;
         power_ff <= 1'b1;
      end else begin
         rise_ff <= rise_in;
         power_ff <= power_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/averaged_throttle_with_press_toggle.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: operation; tdata: sample, time_us
// rsp      out        rsp_tvalid/rsp_tready  tuser: drive_valid; tdata: level, power, off
// csr      in         csr_we                 csr_index, csr_wdata
//
// Each accepted item yields one result in the output register on the next cycle. The
// ring is a row of cells that shift once per sample while power is on, with the running
// sum updated in the same cycle. A new item is taken whenever the output register is
// empty or its result is taken in the same cycle. Synchronous reset empties the ring,
// clears the sum and the rise time, turns power on and loads the default registers.

module averaged_throttle_with_press_toggle #(
   parameter int RING_DEPTH = tav_pkg::RING_DEPTH,
   parameter int SAMPLE_BITS = tav_pkg::SAMPLE_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // Bits from the lowest: operation.
   input  wire logic [tav_pkg::OP_BITS-1:0]            req_tuser,
   // Bits from the lowest: sample, time_us, zero fill.
   input  wire logic [((SAMPLE_BITS+tav_pkg::TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // Bits from the lowest: drive_valid.
   output logic [0:0]                                  rsp_tuser,
   // Bits from the lowest: drive_level, power_on, power_switched_off, zero fill.
   output logic [tav_pkg::RSP_DATA_BITS-1:0]           rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic                                   csr_index,
   input  wire logic [tav_pkg::LIMIT_BITS-1:0]         csr_wdata
);

   logic [tav_pkg::THRESHOLD_BITS-1:0] threshold_ff;
   logic [tav_pkg::THRESHOLD_BITS-1:0] threshold_in;
   logic [tav_pkg::LIMIT_BITS-1:0]     limit_ff;
   logic [tav_pkg::LIMIT_BITS-1:0]     limit_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               drive_valid_ff;
   logic                               drive_valid_in;
   logic [2:0]                         rsp_bits_ff;
   logic [2:0]                         rsp_bits_in;

   logic                               accept;
   logic [tav_pkg::OP_BITS-1:0]        operation;
   logic [SAMPLE_BITS-1:0]             sample;
   logic [tav_pkg::TIME_BITS-1:0]      time_us;
   logic                               sample_en;
   logic                               prime_en;
   logic                               drive_level;
   tav_pkg::power_status_type          status;

   assign operation = req_tuser;
   assign sample = req_tdata[SAMPLE_BITS-1:0];
   assign time_us = req_tdata[SAMPLE_BITS+tav_pkg::TIME_BITS-1:SAMPLE_BITS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign sample_en = accept && (operation == tav_pkg::OP_SAMPLE) && status.power_cur;
   assign prime_en = accept && (operation == tav_pkg::OP_PRIME);

   tav_ring #(
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .sample_en   (sample_en),
      .prime_en    (prime_en),
      .sample      (sample),
      .threshold   (threshold_ff),
      .drive_level (drive_level)
   );

   tav_press u_press (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (operation),
      .time_us     (time_us),
      .press_limit (limit_ff),
      .status      (status)
   );

   always_comb begin
      threshold_in = threshold_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            tav_pkg::CSR_DRIVE_THRESHOLD: begin
               threshold_in = csr_wdata[tav_pkg::THRESHOLD_BITS-1:0];
            end
            tav_pkg::CSR_PRESS_TIME_LIMIT: begin
               limit_in = csr_wdata;
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      drive_valid_in = drive_valid_ff;
      rsp_bits_in = rsp_bits_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         drive_valid_in = sample_en;
         rsp_bits_in = {status.switched_off, status.power_next, sample_en && drive_level};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tav_pkg::RESET_THRESHOLD;
         limit_ff <= tav_pkg::RESET_PRESS_LIMIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_valid_ff <= drive_valid_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = drive_valid_ff;
   assign rsp_tdata = {{(tav_pkg::RSP_DATA_BITS - 3){1'b0}}, rsp_bits_ff};

   a_drive_needs_power: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[1])
      else $error("Drive result reported while power is off.");

   a_off_means_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("Power switched off but still reported on.");

   a_level_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser[0])
      else $error("Drive level set without a processed sample.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input taken while a result transfer is stalled.");

endmodule

`default_nettype wire

// File: sim/averaged_throttle_with_press_toggle_tb.sv
`default_nettype none

module averaged_throttle_with_press_toggle_tb;

   localparam int REQ_BITS = ((tav_pkg::SAMPLE_BITS + tav_pkg::TIME_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 191;
   localparam int LONG_STALL = 300;
   localparam int IDLE_PCT = 9;

   typedef struct {
      logic [tav_pkg::OP_BITS-1:0]     op;
      logic [tav_pkg::SAMPLE_BITS-1:0] reading;
      logic [tav_pkg::TIME_BITS-1:0]   stamp;
   } req_item_type;

   typedef struct {
      logic drive_valid;
      logic drive_level;
      logic power_on;
      logic power_switched_off;
   } drive_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   wire logic                            req_tready;
   logic [tav_pkg::OP_BITS-1:0]          req_tuser = '0;
   logic [REQ_BITS-1:0]                  req_tdata = '0;
   wire logic                            rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   wire logic [0:0]                      rsp_tuser;
   wire logic [tav_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                                 csr_we = 1'b0;
   logic                                 csr_index = 1'b0;
   logic [tav_pkg::LIMIT_BITS-1:0]       csr_wdata = '0;

   averaged_throttle_with_press_toggle uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the throttle state and its registers.
   logic [tav_pkg::SAMPLE_BITS-1:0]    ring_shadow [tav_pkg::RING_DEPTH];
   int unsigned                        sum_shadow = 0;
   int unsigned                        slot_shadow = 0;
   logic [tav_pkg::TIME_BITS-1:0]      rise_shadow = '0;
   logic                               power_shadow = 1'b1;
   logic [tav_pkg::THRESHOLD_BITS-1:0] threshold_shadow = tav_pkg::RESET_THRESHOLD;
   logic [tav_pkg::LIMIT_BITS-1:0]     limit_shadow = tav_pkg::RESET_PRESS_LIMIT;

   req_item_type     pending_items [$];
   drive_result_type expected_results [$];
   req_item_type     offered;
   logic             offering = 1'b0;
   logic             calm = 1'b0;
   logic             stall_request = 1'b0;
   int               stall_left = 0;
   int               errors = 0;
   int unsigned      cycles = 0;

   initial begin
      for (int i = 0; i < tav_pkg::RING_DEPTH; i++) begin
         ring_shadow[i] = '0;
      end
   end

   function automatic drive_result_type throttle_step(req_item_type item);
      drive_result_type              res;
      logic [tav_pkg::TIME_BITS-1:0] held;
      res = '{1'b0, 1'b0, 1'b0, 1'b0};
      case (item.op)
         tav_pkg::OP_SAMPLE: begin
            if (power_shadow) begin
               sum_shadow = sum_shadow - ring_shadow[slot_shadow] + item.reading;
               ring_shadow[slot_shadow] = item.reading;
               slot_shadow = (slot_shadow + 1) % tav_pkg::RING_DEPTH;
               res.drive_valid = 1'b1;
               res.drive_level = (sum_shadow / tav_pkg::RING_DEPTH) > threshold_shadow;
            end
         end
         tav_pkg::OP_RISE: begin
            rise_shadow = item.stamp;
         end
         tav_pkg::OP_FALL: begin
            held = item.stamp - rise_shadow;
            if (held > limit_shadow) begin
               res.power_switched_off = power_shadow;
               power_shadow = !power_shadow;
            end
         end
         default: begin
            for (int i = 0; i < tav_pkg::RING_DEPTH; i++) begin
               ring_shadow[i] = item.reading;
            end
            sum_shadow = item.reading * tav_pkg::RING_DEPTH;
         end
      endcase
      res.power_on = power_shadow;
      return res;
   endfunction

   // Driver: offers the queued items and predicts each accepted one.
   always @(negedge clock) begin
      if (!reset && !offering) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= (calm ? 0 : IDLE_PCT)) begin
            offered = pending_items.pop_front();
            offering = 1'b1;
            req_tvalid <= 1'b1;
            req_tuser <= offered.op;
            req_tdata <= REQ_BITS'({offered.stamp, offered.reading});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_results.push_back(throttle_step(offered));
         offering = 1'b0;
      end
   end

   // Monitor: paces the result channel and checks each transfer.
   always @(negedge clock) begin
      if (stall_request) begin
         stall_left = LONG_STALL;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= (calm ? 0 : IDLE_PCT);
      end
   end

   task automatic check_field(string name, logic want, logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual user %b data %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("drive_valid", want.drive_valid, rsp_tuser[0]);
            check_field("drive_level", want.drive_level, rsp_tdata[0]);
            check_field("power_on", want.power_on, rsp_tdata[1]);
            check_field("power_switched_off", want.power_switched_off, rsp_tdata[2]);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_item(logic [tav_pkg::OP_BITS-1:0] op,
                            logic [tav_pkg::SAMPLE_BITS-1:0] reading,
                            logic [tav_pkg::TIME_BITS-1:0] stamp);
      req_item_type item;
      item.op = op;
      item.reading = reading;
      item.stamp = stamp;
      pending_items.push_back(item);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || offering || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(logic index, logic [tav_pkg::LIMIT_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == tav_pkg::CSR_DRIVE_THRESHOLD) begin
         threshold_shadow = value[tav_pkg::THRESHOLD_BITS-1:0];
      end else begin
         limit_shadow = value;
      end
   endtask

   // Mostly samples and well-formed presses near the limit, with some primes and noise.
   task automatic queue_random(int count);
      int                            made;
      int unsigned                   pick;
      logic [tav_pkg::TIME_BITS-1:0] base;
      logic [tav_pkg::TIME_BITS-1:0] held;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 58) begin
            push_item(tav_pkg::OP_SAMPLE, tav_pkg::SAMPLE_BITS'($urandom),
                      tav_pkg::TIME_BITS'($urandom));
            made++;
         end else if (pick < 63) begin
            push_item(tav_pkg::OP_PRIME, tav_pkg::SAMPLE_BITS'($urandom),
                      tav_pkg::TIME_BITS'($urandom));
            made++;
         end else if (pick < 90) begin
            base = $urandom;
            case ($urandom_range(4))
               0: held = limit_shadow;
               1: held = limit_shadow + 1;
               2: held = limit_shadow - 1;
               3: held = limit_shadow + $urandom_range(1, 1000);
               default: held = $urandom;
            endcase
            push_item(tav_pkg::OP_RISE, tav_pkg::SAMPLE_BITS'($urandom), base);
            made++;
            repeat ($urandom_range(3)) begin
               push_item(tav_pkg::OP_SAMPLE, tav_pkg::SAMPLE_BITS'($urandom),
                         tav_pkg::TIME_BITS'($urandom));
               made++;
            end
            push_item(tav_pkg::OP_FALL, tav_pkg::SAMPLE_BITS'($urandom), base + held);
            made++;
         end else begin
            push_item(tav_pkg::OP_BITS'($urandom), tav_pkg::SAMPLE_BITS'($urandom),
                      tav_pkg::TIME_BITS'($urandom));
            made++;
         end
      end
   endtask

   initial begin
      logic [tav_pkg::THRESHOLD_BITS-1:0] thresholds [PHASE_COUNT];
      logic [tav_pkg::LIMIT_BITS-1:0]     limits [PHASE_COUNT];
      thresholds = '{10'd0, 10'd1023, 10'd0, 10'd511, 10'd0, 10'd300, 10'd1, 10'd1022};
      limits = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd500000, 32'd0, 32'd1,
                 32'hFFFF_FFFE};
      thresholds[2] = tav_pkg::THRESHOLD_BITS'($urandom_range(1023));
      thresholds[4] = tav_pkg::THRESHOLD_BITS'($urandom_range(1023));
      limits[3] = $urandom;
      limits[5] = $urandom_range(1, 5000);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      push_item(tav_pkg::OP_SAMPLE, 10'd0, 32'd0);
      push_item(tav_pkg::OP_SAMPLE, 10'd1023, 32'hFFFF_FFFF);
      push_item(tav_pkg::OP_PRIME, 10'd1023, 32'd0);
      push_item(tav_pkg::OP_SAMPLE, 10'd1023, 32'd0);
      push_item(tav_pkg::OP_SAMPLE, 10'd0, 32'd0);
      push_item(tav_pkg::OP_PRIME, 10'd301, 32'd0);
      push_item(tav_pkg::OP_SAMPLE, 10'd301, 32'd0);
      push_item(tav_pkg::OP_PRIME, 10'd300, 32'd0);
      push_item(tav_pkg::OP_SAMPLE, 10'd300, 32'd0);
      push_item(tav_pkg::OP_FALL, 10'd0, 32'd500000);
      push_item(tav_pkg::OP_FALL, 10'd0, 32'd500001);
      push_item(tav_pkg::OP_SAMPLE, 10'd777, 32'd0);
      push_item(tav_pkg::OP_PRIME, 10'd5, 32'd0);
      push_item(tav_pkg::OP_RISE, 10'd0, 32'hFFFF_FFF0);
      push_item(tav_pkg::OP_FALL, 10'd0, 32'd500000);
      push_item(tav_pkg::OP_SAMPLE, 10'h2AA, 32'h5555_5555);
      push_item(tav_pkg::OP_SAMPLE, 10'h155, 32'hAAAA_AAAA);
      push_item(tav_pkg::OP_RISE, 10'd0, 32'd100);
      push_item(tav_pkg::OP_FALL, 10'd0, 32'd500100);
      push_item(tav_pkg::OP_FALL, 10'd0, 32'd99);
      push_item(tav_pkg::OP_RISE, 10'h3FF, 32'd0);
      push_item(tav_pkg::OP_FALL, 10'h3FF, 32'hFFFF_FFFF);
      push_item(tav_pkg::OP_SAMPLE, 10'd1023, 32'hFFFF_FFFF);
      push_item(tav_pkg::OP_FALL, 10'd0, 32'hAAAA_AAAA);
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(tav_pkg::CSR_DRIVE_THRESHOLD,
                        ($urandom & ~32'h3FF) | tav_pkg::LIMIT_BITS'(thresholds[p]));
         write_register(tav_pkg::CSR_PRESS_TIME_LIMIT, limits[p]);
         calm = (p == 3);
         queue_random(PHASE_ITEMS);
         if (p == 5) begin
            stall_request = 1'b1;
         end
         wait_drained();
      end
      calm = 1'b0;

      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: averaged_throttle_with_press_toggle.f
rtl/tav_pkg.sv
rtl/tav_cell.sv
rtl/tav_ring.sv
rtl/tav_press.sv
rtl/averaged_throttle_with_press_toggle.sv
sim/averaged_throttle_with_press_toggle_tb.sv
